/* hw/rtl/sov_pkg.sv */
`default_nettype none
package sov_pkg;

  localparam int FREQ_W    = 15;
  localparam int RATE_W    = 18;
  localparam int SAMPLE_W  = 16;
  localparam int COUNT_W   = 16;
  localparam int ROM_W     = 15;

  localparam logic [RATE_W-1:0] RATE_RESET   = 18'd48000;
  localparam logic [63:0]       HALF_PI_Q30  = 64'd1686629713;
  localparam logic [63:0]       AMPLITUDE    = 64'd32767;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RATE,
    ST_PREP,
    ST_DIV_PHASE,
    ST_LOOK,
    ST_FIN
  } sov_state_t;

  // Quarter-wave entry k of a table with 2**q_log2 steps per quarter turn.
  // Angle and Taylor terms run in Q30, up to the x^15 term.
  function automatic logic [ROM_W-1:0] sov_rom_entry(input int unsigned k,
                                                     input int unsigned q_log2);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] v;
    x    = (64'(k) * HALF_PI_Q30) >> q_log2;
    x2   = (x * x) >> 30;
    term = x;
    s    = x;
    term = ((term * x2) >> 30) / 64'd6;
    s    = (s >= term) ? s - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd20;
    s    = s + term;
    term = ((term * x2) >> 30) / 64'd42;
    s    = (s >= term) ? s - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd72;
    s    = s + term;
    term = ((term * x2) >> 30) / 64'd110;
    s    = (s >= term) ? s - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd156;
    s    = s + term;
    term = ((term * x2) >> 30) / 64'd210;
    s    = (s >= term) ? s - term : 64'd0;
    v    = ((s + 64'd16) * AMPLITUDE) >> 30;
    if (v > AMPLITUDE) begin
      v = AMPLITUDE;
    end
    return v[ROM_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/sov_in_if.sv */
`default_nettype none
interface sov_in_if
  import sov_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] freq_value;

  modport source (output valid, output freq_value, input ready);
  modport sink   (input valid, input freq_value, output ready);
endinterface
`default_nettype wire

/* hw/rtl/sov_out_if.sv */
`default_nettype none
interface sov_out_if
  import sov_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

/* hw/rtl/sine_oscillator_variable_freq.sv */
`default_nettype none
// Sine oscillator with a per-word frequency. Each input word is one sample
// tick carrying a frequency in hertz; each tick returns one signed 16-bit
// sample. A zero frequency repeats the last sample without advancing the
// phase. The period is sample_rate / freq (at least 1); sample_rate is
// written through cfg_we/cfg_wdata; the user must do so only while the block
// is idle, as the block does not enforce it (reset value 48000). One shared
// restoring divider, retiring one quotient bit per cycle, computes first
// RATE_W bits for the period and then COUNT_W + PHASE_FRACTION_BITS bits
// for the phase fraction, followed by a registered quarter-wave table read;
// a zero-frequency word skips both. The input is ready again in the same
// cycle that the result is registered. The input is not ready while a word
// is in work; a finished sample waits in the output register.
module sine_oscillator_variable_freq
  import sov_pkg::*;
#(
  parameter int PHASE_FRACTION_BITS = 16,
  parameter int SINE_TABLE_DEPTH    = 1024
) (
  input  wire               clk,
  input  wire               rst_n,
  sov_in_if.sink            in_ch,
  sov_out_if.source         out_ch,
  input  wire               cfg_we,
  input  wire  [RATE_W-1:0] cfg_wdata
);

  localparam int PFB    = PHASE_FRACTION_BITS;
  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int QB     = IDX_W - 2;
  localparam int QSTEPS = 1 << QB;
  localparam int AW     = QB + 1;
  localparam int DW     = COUNT_W + PFB;
  localparam int DVS_W  = RATE_W;
  localparam int CNT_W  = $clog2(DW + 1);

  // Quarter-wave table, built at elaboration
  logic [ROM_W-1:0] rom_tab [QSTEPS+1];
  for (genvar k = 0; k <= QSTEPS; k++) begin : g_rom
    assign rom_tab[k] = sov_rom_entry(k, QB);
  end

  sov_state_t state_r, state_nxt;

  logic [RATE_W-1:0]          rate_r;
  logic [COUNT_W-1:0]         count_r, count_nxt;
  logic [SAMPLE_W-1:0]        held_r, held_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]        out_sample_r, out_sample_nxt;
  logic                       hold_r, hold_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;

  logic [DW-1:0]              dvd_r, dvd_nxt;
  logic [DVS_W-1:0]           dvs_r, dvs_nxt;
  logic [DVS_W-1:0]           rem_r, rem_nxt;
  logic [ROM_W-1:0]           rom_data_r, rom_data_nxt;
  logic                       neg_r, neg_nxt;

  // Divider step
  logic [DVS_W:0]             rem_sh;
  logic                       ge;
  logic [DVS_W:0]             diff;

  logic [RATE_W-1:0]          period;
  logic [COUNT_W-1:0]         count_eff;
  logic [PFB-1:0]             phase;
  logic [IDX_W-1:0]           idx;
  logic [1:0]                 quad;
  logic [QB-1:0]              off;
  logic [AW-1:0]              addr;
  logic [SAMPLE_W-1:0]        wave;
  logic                       in_fire;
  logic                       out_free;

  assign rem_sh = {rem_r, dvd_r[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};
  assign diff   = rem_sh - {1'b0, dvs_r};

  // Clamp a zero quotient to a period of one
  assign period    = (dvd_r[RATE_W-1:0] == '0) ? RATE_W'(1) : dvd_r[RATE_W-1:0];
  assign count_eff = (RATE_W'(count_r) > period) ? '0 : count_r;

  // Table index from the phase fraction
  assign phase = dvd_r[PFB-1:0];
  if (PFB >= IDX_W) begin : g_idx_shr
    assign idx = phase[PFB-1 -: IDX_W];
  end else begin : g_idx_shl
    assign idx = {phase, {(IDX_W-PFB){1'b0}}};
  end
  assign quad = idx[IDX_W-1 -: 2];
  assign off  = idx[QB-1:0];
  assign addr = quad[0] ? (AW'(QSTEPS) - {1'b0, off}) : {1'b0, off};

  assign wave = neg_r ? (SAMPLE_W'(0) - SAMPLE_W'(rom_data_r)) : SAMPLE_W'(rom_data_r);

  assign in_fire  = in_ch.valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = out_sample_r;

  // Sequencer: next state and datapath
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    held_nxt       = held_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    hold_nxt       = hold_r;
    cnt_nxt        = cnt_r;
    dvd_nxt        = dvd_r;
    dvs_nxt        = dvs_r;
    rem_nxt        = rem_r;
    rom_data_nxt   = rom_data_r;
    neg_nxt        = neg_r;

    // drop the result once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          hold_nxt = (in_ch.freq_value == '0);
          if (in_ch.freq_value == '0) begin
            state_nxt = ST_FIN;
          end else begin
            dvd_nxt   = {rate_r, {(DW-RATE_W){1'b0}}};
            dvs_nxt   = DVS_W'(in_ch.freq_value);
            rem_nxt   = '0;
            cnt_nxt   = CNT_W'(RATE_W);
            state_nxt = ST_DIV_RATE;
          end
        end
      end
      ST_DIV_RATE, ST_DIV_PHASE: begin
        rem_nxt = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        dvd_nxt = {dvd_r[DW-2:0], ge};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = (state_r == ST_DIV_RATE) ? ST_PREP : ST_LOOK;
        end
      end
      ST_PREP: begin
        count_nxt = count_eff;
        dvd_nxt   = {count_eff, {PFB{1'b0}}};
        dvs_nxt   = period;
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(DW);
        state_nxt = ST_DIV_PHASE;
      end
      ST_LOOK: begin
        rom_data_nxt = rom_tab[addr];
        neg_nxt      = quad[1];
        state_nxt    = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (hold_r) begin
            out_sample_nxt = held_r;
          end else begin
            out_sample_nxt = wave;
            held_nxt       = wave;
            count_nxt      = count_r + COUNT_W'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rate_r      <= RATE_RESET;
      count_r     <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        rate_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
    hold_r       <= hold_nxt;
    cnt_r        <= cnt_nxt;
    dvd_r        <= dvd_nxt;
    dvs_r        <= dvs_nxt;
    rem_r        <= rem_nxt;
    rom_data_r   <= rom_data_nxt;
    neg_r        <= neg_nxt;
  end

endmodule
`default_nettype wire
